### design/sps_pkg.sv
// ---------------------------------------------------------------------------
// SPS parser package
// Shared types, status codes and constants of the SPS header parser.
// ---------------------------------------------------------------------------
package sps_pkg;

    localparam int MAX_CODE_BITS_DEF = 32;
    localparam int DIM_BITS_DEF      = 16;
    // Macroblock size is 16, so scaling by it is a shift by four.
    localparam int MB_SHIFT          = 4;

    localparam logic [2:0] STS_OK      = 3'd0;
    localparam logic [2:0] STS_NOT_SPS = 3'd1;
    localparam logic [2:0] STS_TRUNC   = 3'd2;
    localparam logic [2:0] STS_OVF     = 3'd3;
    localparam logic [2:0] STS_CROP    = 3'd4;
    localparam logic [2:0] STS_SCALING = 3'd5;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       last_byte;
    } sps_in_t;

    typedef struct packed {
        logic [2:0]  status;
        logic [15:0] frame_width;
        logic [15:0] frame_height;
        logic [7:0]  profile_code;
        logic [7:0]  level_code;
        logic [4:0]  param_set_id;
        logic [1:0]  chroma_format;
        logic [3:0]  frame_num_bits_minus4;
        logic [1:0]  order_count_type;
        logic [7:0]  ref_frame_count;
        logic        frames_only;
        logic        vui_present;
    } sps_out_t;

    typedef struct packed {
        logic [7:0] profile;
        logic [7:0] level;
        logic [4:0] sps_id;
        logic [7:0] chroma;
        logic [3:0] fnum;
        logic [1:0] poc;
        logic [7:0] nref;
        logic       fmo;
        logic       vui;
        logic       high;
    } sps_fields_t;

    typedef struct packed {
        sps_fields_t fld;
        logic [15:0] wib;
        logic [15:0] hiu;
        logic [15:0] crop0;
        logic [15:0] crop1;
        logic [15:0] crop2;
        logic [15:0] crop3;
        logic [2:0]  err;
        logic        done;
    } sps_parse_t;

    function automatic logic is_high_profile(input logic [7:0] p);
        is_high_profile = (p == 8'd100) || (p == 8'd110) || (p == 8'd122) ||
                          (p == 8'd244) || (p == 8'd44)  || (p == 8'd83)  ||
                          (p == 8'd86)  || (p == 8'd118) || (p == 8'd128) ||
                          (p == 8'd138) || (p == 8'd139) || (p == 8'd134);
    endfunction

endpackage

### design/sps_bit_parser.sv
// ---------------------------------------------------------------------------
// SPS bit parser
// Consumes one bit per cycle, when bit_valid is set, through a shared
// fixed-width and Exp-Golomb reader, stepping through the SPS elements.
// ---------------------------------------------------------------------------
module sps_bit_parser
    import sps_pkg::*;
#(
    parameter int MAX_CODE_BITS = MAX_CODE_BITS_DEF
)
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       bit_valid,
    input  logic       bit_in,
    input  logic       clear,
    output sps_parse_t parse
);

    localparam int CW   = MAX_CODE_BITS;
    localparam int CNTW = $clog2(MAX_CODE_BITS + 1);

    // Captured fields after reset: everything zero except a 4:2:0 chroma format.
    localparam sps_fields_t FLD_RST = '{profile: 8'd0, level: 8'd0, sps_id: 5'd0,
                                        chroma: 8'd1, fnum: 4'd0, poc: 2'd0,
                                        nref: 8'd0, fmo: 1'b0, vui: 1'b0,
                                        high: 1'b0};

    typedef enum logic [30:0] {
        ST_HDR     = 31'h0000_0001,
        ST_FU      = 31'h0000_0002,
        ST_PROFILE = 31'h0000_0004,
        ST_CONSTR  = 31'h0000_0008,
        ST_LEVEL   = 31'h0000_0010,
        ST_SPSID   = 31'h0000_0020,
        ST_CHROMA  = 31'h0000_0040,
        ST_SEPCOL  = 31'h0000_0080,
        ST_DEPTH_L = 31'h0000_0100,
        ST_DEPTH_C = 31'h0000_0200,
        ST_BYPASS  = 31'h0000_0400,
        ST_SCALING = 31'h0000_0800,
        ST_FNUM    = 31'h0000_1000,
        ST_POCTYPE = 31'h0000_2000,
        ST_POCLSB  = 31'h0000_4000,
        ST_DZERO   = 31'h0000_8000,
        ST_OFF_NR  = 31'h0001_0000,
        ST_OFF_TB  = 31'h0002_0000,
        ST_CYCLE   = 31'h0004_0000,
        ST_CYCOFF  = 31'h0008_0000,
        ST_NREF    = 31'h0010_0000,
        ST_GAPS    = 31'h0020_0000,
        ST_WIDTH   = 31'h0040_0000,
        ST_HEIGHT  = 31'h0080_0000,
        ST_FMO     = 31'h0100_0000,
        ST_MBAFF   = 31'h0200_0000,
        ST_D8      = 31'h0400_0000,
        ST_CROPF   = 31'h0800_0000,
        ST_CROP    = 31'h1000_0000,
        ST_VUI     = 31'h2000_0000,
        ST_DONE    = 31'h4000_0000
    } sps_step_t;

    sps_step_t      step_reg, step_next;
    logic [CNTW-1:0] cnt_reg, cnt_next, cnt_inc;
    logic [CNTW-1:0] lz_reg, lz_next;
    logic [CW-1:0]   acc_reg, acc_next, acc_sh, eg_val, val;
    logic [7:0]      loop_reg, loop_next, loop_sat;
    logic [15:0]     wib_reg, wib_next, hiu_reg, hiu_next;
    logic [15:0]     crop_reg [4];
    logic [15:0]     crop_next [4];
    sps_fields_t     fld_reg, fld_next;
    logic [2:0]      err_reg, err_next;
    logic            fixed8, fixed1, elem_done;

    function automatic logic [7:0] sat8(input logic [CW-1:0] v, input logic [7:0] m);
        sat8 = (v > CW'(m)) ? m : v[7:0];
    endfunction

    function automatic logic [15:0] sat16(input logic [CW-1:0] v);
        sat16 = (v > CW'(16'hFFFF)) ? 16'hFFFF : v[15:0];
    endfunction

    assign fixed8 = step_reg inside {ST_HDR, ST_FU, ST_PROFILE, ST_CONSTR, ST_LEVEL};
    assign fixed1 = step_reg inside {ST_SEPCOL, ST_BYPASS, ST_SCALING, ST_DZERO, ST_GAPS,
                                     ST_FMO, ST_MBAFF, ST_D8, ST_CROPF, ST_VUI};
    assign acc_sh  = {acc_reg[CW-2:0], bit_in};
    assign cnt_inc = cnt_reg + CNTW'(1);
    // The suffix holds exactly lz bits, so the leading one can be ORed in.
    assign eg_val  = ((CW'(1) << lz_reg) | acc_sh) - CW'(1);
    assign loop_sat = sat8(val, 8'd255);

    always_comb
    begin
        step_next = step_reg;
        cnt_next  = cnt_reg;
        lz_next   = lz_reg;
        acc_next  = acc_reg;
        loop_next = loop_reg;
        wib_next  = wib_reg;
        hiu_next  = hiu_reg;
        crop_next = crop_reg;
        fld_next  = fld_reg;
        err_next  = err_reg;
        elem_done = 1'b0;
        val       = '0;

        if (clear)
        begin
            step_next = ST_HDR;
            cnt_next  = '0;
            lz_next   = '0;
            acc_next  = '0;
            loop_next = '0;
            wib_next  = '0;
            hiu_next  = '0;
            crop_next = '{default: 16'd0};
            fld_next  = FLD_RST;
            err_next  = STS_OK;
        end
        else if (bit_valid && step_reg != ST_DONE)
        begin
            if (fixed8 || fixed1)
            begin
                acc_next = acc_sh;
                cnt_next = cnt_inc;
                if (fixed1 || cnt_inc == CNTW'(8))
                begin
                    elem_done = 1'b1;
                    val       = acc_sh;
                end
            end
            else if (cnt_reg == '0)
            begin
                if (!bit_in)
                begin
                    lz_next = lz_reg + CNTW'(1);
                    if (lz_reg == CNTW'(CW - 1))
                    begin
                        err_next  = STS_OVF;
                        step_next = ST_DONE;
                    end
                end
                else if (lz_reg == '0)
                begin
                    elem_done = 1'b1;
                end
                else
                begin
                    cnt_next = CNTW'(1);
                    acc_next = '0;
                end
            end
            else
            begin
                acc_next = acc_sh;
                cnt_next = cnt_inc;
                if (cnt_reg >= lz_reg)
                begin
                    elem_done = 1'b1;
                    val       = eg_val;
                end
            end

            if (elem_done)
            begin
                cnt_next  = '0;
                lz_next   = '0;
                acc_next  = '0;
                step_next = sps_step_t'(step_reg << 1);
                case (step_reg)
                    ST_HDR:
                    begin
                        if (val[4:0] == 5'd28)
                            step_next = ST_FU;
                        else if (val[4:0] == 5'd7)
                            step_next = ST_PROFILE;
                        else
                        begin
                            err_next  = STS_NOT_SPS;
                            step_next = ST_DONE;
                        end
                    end
                    ST_FU:
                    begin
                        if (val[7] && !val[6] && val[4:0] == 5'd7)
                            step_next = ST_PROFILE;
                        else
                        begin
                            err_next  = STS_NOT_SPS;
                            step_next = ST_DONE;
                        end
                    end
                    ST_PROFILE:
                    begin
                        fld_next.profile = val[7:0];
                        fld_next.high    = is_high_profile(val[7:0]);
                    end
                    ST_LEVEL:
                        fld_next.level = val[7:0];
                    ST_SPSID:
                    begin
                        fld_next.sps_id = (val > CW'(31)) ? 5'd31 : val[4:0];
                        step_next = fld_reg.high ? ST_CHROMA : ST_FNUM;
                    end
                    ST_CHROMA:
                    begin
                        fld_next.chroma = loop_sat;
                        step_next = (val == CW'(3)) ? ST_SEPCOL : ST_DEPTH_L;
                    end
                    ST_SCALING:
                    begin
                        if (val[0])
                        begin
                            err_next  = STS_SCALING;
                            step_next = ST_DONE;
                        end
                    end
                    ST_FNUM:
                        fld_next.fnum = (val > CW'(15)) ? 4'd15 : val[3:0];
                    ST_POCTYPE:
                    begin
                        fld_next.poc = (val > CW'(3)) ? 2'd3 : val[1:0];
                        if (val == '0)
                            step_next = ST_POCLSB;
                        else if (val == CW'(1))
                            step_next = ST_DZERO;
                        else
                            step_next = ST_NREF;
                    end
                    ST_POCLSB:
                        step_next = ST_NREF;
                    ST_CYCLE:
                    begin
                        loop_next = loop_sat;
                        step_next = (loop_sat != 8'd0) ? ST_CYCOFF : ST_NREF;
                    end
                    ST_CYCOFF:
                    begin
                        loop_next = loop_reg - 8'd1;
                        step_next = (loop_reg != 8'd1) ? ST_CYCOFF : ST_NREF;
                    end
                    ST_NREF:
                        fld_next.nref = loop_sat;
                    ST_WIDTH:
                        wib_next = sat16(val);
                    ST_HEIGHT:
                        hiu_next = sat16(val);
                    ST_FMO:
                    begin
                        fld_next.fmo = val[0];
                        step_next = val[0] ? ST_D8 : ST_MBAFF;
                    end
                    ST_CROPF:
                    begin
                        loop_next = 8'd0;
                        step_next = val[0] ? ST_CROP : ST_VUI;
                    end
                    ST_CROP:
                    begin
                        crop_next[loop_reg[1:0]] = sat16(val);
                        loop_next = loop_reg + 8'd1;
                        step_next = (loop_reg >= 8'd3) ? ST_VUI : ST_CROP;
                    end
                    ST_VUI:
                    begin
                        fld_next.vui = val[0];
                        step_next = ST_DONE;
                    end
                    default:
                    begin
                    end
                endcase
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            step_reg <= ST_HDR;
            cnt_reg  <= '0;
            lz_reg   <= '0;
            acc_reg  <= '0;
            loop_reg <= '0;
            wib_reg  <= '0;
            hiu_reg  <= '0;
            crop_reg <= '{default: 16'd0};
            fld_reg  <= FLD_RST;
            err_reg  <= STS_OK;
        end
        else
        begin
            step_reg <= step_next;
            cnt_reg  <= cnt_next;
            lz_reg   <= lz_next;
            acc_reg  <= acc_next;
            loop_reg <= loop_next;
            wib_reg  <= wib_next;
            hiu_reg  <= hiu_next;
            crop_reg <= crop_next;
            fld_reg  <= fld_next;
            err_reg  <= err_next;
        end
    end

    assign parse.fld   = fld_reg;
    assign parse.wib   = wib_reg;
    assign parse.hiu   = hiu_reg;
    assign parse.crop0 = crop_reg[0];
    assign parse.crop1 = crop_reg[1];
    assign parse.crop2 = crop_reg[2];
    assign parse.crop3 = crop_reg[3];
    assign parse.err   = err_reg;
    assign parse.done  = (step_reg == ST_DONE);

endmodule

### design/sps_size_calc.sv
// ---------------------------------------------------------------------------
// SPS size calculator
// Forms the full frame size and crop amounts in one registered stage, then
// checks the crop and subtracts it to give the status and cropped size.
// ---------------------------------------------------------------------------
module sps_size_calc
    import sps_pkg::*;
#(
    parameter int DIM_BITS = DIM_BITS_DEF
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        load,
    input  sps_parse_t  parse,
    output logic [2:0]  status,
    output logic [15:0] frame_width,
    output logic [15:0] frame_height
);

    localparam int XW = 22;
    localparam logic [XW-1:0] LIM = XW'((64'd1 << DIM_BITS) - 64'd1);

    logic [XW-1:0] w_reg, h_reg, ux_reg, uy_reg;
    logic [XW-1:0] w_next, h_next, ux_next, uy_next, sum_x, sum_y;
    logic [2:0]    err_reg;
    logic          done_reg, unit_x2, unit_y2, bad;

    // Horizontal unit is two for 4:2:0 and 4:2:2 (and unknown formats);
    // the vertical unit doubles again for 4:2:0 and unknown formats.
    assign unit_x2 = !(parse.fld.chroma == 8'd0 || parse.fld.chroma == 8'd3);
    assign unit_y2 = unit_x2 && parse.fld.chroma != 8'd2;
    assign sum_x   = XW'(parse.crop0) + XW'(parse.crop1);
    assign sum_y   = XW'(parse.crop2) + XW'(parse.crop3);
    assign w_next  = (XW'(parse.wib) + XW'(1)) << MB_SHIFT;
    assign h_next  = ((XW'(parse.hiu) + XW'(1)) << MB_SHIFT) << (parse.fld.fmo ? 0 : 1);
    assign ux_next = unit_x2 ? (sum_x << 1) : sum_x;
    assign uy_next = (sum_y << (parse.fld.fmo ? 0 : 1)) << (unit_y2 ? 1 : 0);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            err_reg  <= STS_OK;
            done_reg <= 1'b0;
        end
        else if (load)
        begin
            err_reg  <= parse.err;
            done_reg <= parse.done;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            w_reg  <= w_next;
            h_reg  <= h_next;
            ux_reg <= ux_next;
            uy_reg <= uy_next;
        end
    end

    assign bad = (w_reg > LIM) || (h_reg > LIM) || (ux_reg >= w_reg) || (uy_reg >= h_reg);

    always_comb
    begin
        frame_width  = 16'd0;
        frame_height = 16'd0;
        if (err_reg != STS_OK)
            status = err_reg;
        else if (!done_reg)
            status = STS_TRUNC;
        else if (bad)
            status = STS_CROP;
        else
        begin
            status       = STS_OK;
            frame_width  = 16'(w_reg - ux_reg);
            frame_height = 16'(h_reg - uy_reg);
        end
    end

endmodule

### design/sps_header_parser.sv
// ---------------------------------------------------------------------------
// SPS header parser
// Parses an H.264 sequence parameter set from a byte-wide NAL unit stream
// and returns one summary word at the end of each NAL unit.
// ---------------------------------------------------------------------------
// Each input word carries one NAL unit byte and a last flag. The byte is
// read most significant bit first, one bit per clock, through a single
// shared field reader that handles both fixed-width elements and
// Exp-Golomb codes. While a byte is being read the input is stalled,
// except in the final bit cycle of a byte that is not the last, where the
// next byte may already be taken. After the last byte the calculate state
// forms the full size and crop amounts in registers, and the emit state
// checks the crop and subtracts it; the summary word is then loaded into
// the output register as soon as that register is free, so it may wait
// behind an earlier summary still held downstream. The parser clears
// itself as the summary is loaded, ready for the next NAL unit. Status
// codes are: ok, not an SPS, truncated, Exp-Golomb code too long, bad
// crop, and scaling lists present (unsupported). The cropped width and
// height are zero unless the status is ok. Emulation-prevention bytes are
// not removed and VUI contents are ignored.
// ---------------------------------------------------------------------------
module sps_header_parser
    import sps_pkg::*;
#(
    parameter int MAX_CODE_BITS = MAX_CODE_BITS_DEF,
    parameter int DIM_BITS      = DIM_BITS_DEF
)
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     nal_valid,
    output logic     nal_stall,
    input  sps_in_t  nal_word,
    output logic     sps_valid,
    input  logic     sps_stall,
    output sps_out_t sps_word
);

    typedef enum logic [3:0] {
        SEQ_IDLE  = 4'b0001,
        SEQ_SHIFT = 4'b0010,
        SEQ_CALC  = 4'b0100,
        SEQ_EMIT  = 4'b1000
    } seq_state_t;

    seq_state_t  state_reg, state_next;
    logic [7:0]  byte_reg, byte_next;
    logic        last_reg, last_next;
    logic [2:0]  bit_cnt_reg, bit_cnt_next;
    logic        out_valid_reg, out_valid_next;
    sps_out_t    out_reg, out_next;
    logic        accept, out_free, emit;
    sps_parse_t  parse;
    logic [2:0]  status;
    logic [15:0] frame_width, frame_height;

    // A new word may enter when idle, or in the last bit cycle of a byte
    // that does not end the NAL unit.
    assign nal_stall = !((state_reg == SEQ_IDLE) ||
                         (state_reg == SEQ_SHIFT && bit_cnt_reg == 3'd7 && !last_reg));
    assign accept    = nal_valid && !nal_stall;
    assign out_free  = !out_valid_reg || !sps_stall;
    assign emit      = (state_reg == SEQ_EMIT) && out_free;

    sps_bit_parser #(
        .MAX_CODE_BITS (MAX_CODE_BITS)
    ) u_parser (
        .clk       (clk),
        .rst_n     (rst_n),
        .bit_valid (state_reg == SEQ_SHIFT),
        .bit_in    (byte_reg[7]),
        .clear     (emit),
        .parse     (parse)
    );

    sps_size_calc #(
        .DIM_BITS (DIM_BITS)
    ) u_size (
        .clk          (clk),
        .rst_n        (rst_n),
        .load         (state_reg == SEQ_CALC),
        .parse        (parse),
        .status       (status),
        .frame_width  (frame_width),
        .frame_height (frame_height)
    );

    always_comb
    begin
        state_next   = state_reg;
        byte_next    = byte_reg;
        last_next    = last_reg;
        bit_cnt_next = bit_cnt_reg;

        case (state_reg)
            SEQ_IDLE:
            begin
                if (accept)
                begin
                    state_next   = SEQ_SHIFT;
                    byte_next    = nal_word.data_byte;
                    last_next    = nal_word.last_byte;
                    bit_cnt_next = 3'd0;
                end
            end
            SEQ_SHIFT:
            begin
                byte_next    = {byte_reg[6:0], 1'b0};
                bit_cnt_next = bit_cnt_reg + 3'd1;
                if (bit_cnt_reg == 3'd7)
                begin
                    if (last_reg)
                        state_next = SEQ_CALC;
                    else if (accept)
                    begin
                        byte_next    = nal_word.data_byte;
                        last_next    = nal_word.last_byte;
                        bit_cnt_next = 3'd0;
                    end
                    else
                        state_next = SEQ_IDLE;
                end
            end
            SEQ_CALC:
                state_next = SEQ_EMIT;
            SEQ_EMIT:
            begin
                if (out_free)
                    state_next = SEQ_IDLE;
            end
            default:
                state_next = SEQ_IDLE;
        endcase
    end

    // The summary word is built from the parser's registers before they
    // are cleared in the same cycle.
    always_comb
    begin
        out_next                       = out_reg;
        out_valid_next                 = out_valid_reg && sps_stall;
        if (emit)
        begin
            out_valid_next                 = 1'b1;
            out_next.status                = status;
            out_next.frame_width           = frame_width;
            out_next.frame_height          = frame_height;
            out_next.profile_code          = parse.fld.profile;
            out_next.level_code            = parse.fld.level;
            out_next.param_set_id          = parse.fld.sps_id;
            out_next.chroma_format         = (parse.fld.chroma > 8'd3) ? 2'd3
                                                                       : parse.fld.chroma[1:0];
            out_next.frame_num_bits_minus4 = parse.fld.fnum;
            out_next.order_count_type      = parse.fld.poc;
            out_next.ref_frame_count       = parse.fld.nref;
            out_next.frames_only           = parse.fld.fmo;
            out_next.vui_present           = parse.fld.vui;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= SEQ_IDLE;
            bit_cnt_reg   <= 3'd0;
            last_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            bit_cnt_reg   <= bit_cnt_next;
            last_reg      <= last_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        byte_reg <= byte_next;
        out_reg  <= out_next;
    end

    assign sps_valid = out_valid_reg;
    assign sps_word  = out_reg;

endmodule

### tb/sv/sps_checker.sv
// ---------------------------------------------------------------------------
// SPS parser checker
// Watches both channels of the SPS header parser, predicts each summary word
// from the accepted NAL unit bytes and compares it field by field.
// ---------------------------------------------------------------------------
module sps_checker
    import sps_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     nal_valid,
    input  logic     nal_stall,
    input  sps_in_t  nal_word,
    input  logic     sps_valid,
    input  logic     sps_stall,
    input  sps_out_t sps_word,
    output int       fail_count,
    output int       outstanding
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam int CODE_LIMIT = 32;
    localparam int DIM_LIMIT  = 16;

    typedef enum logic [5:0] {
        S_HDR, S_FU, S_PROFILE, S_CONSTR, S_LEVEL, S_SPSID, S_CHROMA, S_SEPCOL,
        S_DEPTH_L, S_DEPTH_C, S_BYPASS, S_SCALING, S_FNUM, S_POCTYPE, S_POCLSB,
        S_DZERO, S_OFF_NR, S_OFF_TB, S_CYCLE, S_CYCOFF, S_NREF, S_GAPS, S_WIDTH,
        S_HEIGHT, S_FMO, S_MBAFF, S_D8, S_CROPF, S_CROP, S_VUI, S_DONE
    } step_e;

    step_e       step;
    int          bits_in;
    int          zeros;
    logic [31:0] acc;
    int          loops;
    logic [15:0] wib, hiu;
    logic [15:0] crop [4];
    sps_fields_t fld;
    logic [2:0]  err;
    sps_out_t    summary_q [$];

    function automatic int fixed_width(step_e s);
        case (s)
            S_HDR, S_FU, S_PROFILE, S_CONSTR, S_LEVEL: return 8;
            S_SEPCOL, S_BYPASS, S_SCALING, S_DZERO, S_GAPS,
            S_FMO, S_MBAFF, S_D8, S_CROPF, S_VUI: return 1;
            default: return 0;
        endcase
    endfunction

    function automatic logic high_branch(logic [7:0] p);
        return p inside {8'd100, 8'd110, 8'd122, 8'd244, 8'd44, 8'd83,
                         8'd86, 8'd118, 8'd128, 8'd138, 8'd139, 8'd134};
    endfunction

    task automatic clear_parser();
        step = S_HDR;
        bits_in = 0;
        zeros = 0;
        acc = '0;
        loops = 0;
        wib = '0;
        hiu = '0;
        foreach (crop[i]) crop[i] = '0;
        fld = '0;
        fld.chroma = 8'd1;
        err = STS_OK;
    endtask

    task automatic abort_parse(logic [2:0] code);
        err = code;
        step = S_DONE;
    endtask

    // One syntax element is complete; store it and choose the next step.
    task automatic element_done(longint unsigned v);
        step_e nxt;
        nxt = step_e'(step + 1);
        bits_in = 0;
        zeros = 0;
        acc = '0;
        case (step)
            S_HDR:
                if (v[4:0] == 5'd28) nxt = S_FU;
                else if (v[4:0] == 5'd7) nxt = S_PROFILE;
                else begin abort_parse(STS_NOT_SPS); return; end
            S_FU:
                if (v[7] && !v[6] && v[4:0] == 5'd7) nxt = S_PROFILE;
                else begin abort_parse(STS_NOT_SPS); return; end
            S_PROFILE: begin fld.profile = v[7:0]; fld.high = high_branch(v[7:0]); end
            S_LEVEL: fld.level = v[7:0];
            S_SPSID: begin
                fld.sps_id = (v > 31) ? 5'd31 : v[4:0];
                nxt = fld.high ? S_CHROMA : S_FNUM;
            end
            S_CHROMA: begin
                fld.chroma = (v > 255) ? 8'd255 : v[7:0];
                nxt = (v == 3) ? S_SEPCOL : S_DEPTH_L;
            end
            S_SCALING: if (v != 0) begin abort_parse(STS_SCALING); return; end
            S_FNUM: fld.fnum = (v > 15) ? 4'd15 : v[3:0];
            S_POCTYPE: begin
                fld.poc = (v > 3) ? 2'd3 : v[1:0];
                nxt = (v == 0) ? S_POCLSB : (v == 1) ? S_DZERO : S_NREF;
            end
            S_POCLSB: nxt = S_NREF;
            S_CYCLE: begin
                loops = (v > 255) ? 255 : int'(v);
                nxt = (loops != 0) ? S_CYCOFF : S_NREF;
            end
            S_CYCOFF: begin
                loops--;
                nxt = (loops != 0) ? S_CYCOFF : S_NREF;
            end
            S_NREF: fld.nref = (v > 255) ? 8'd255 : v[7:0];
            S_WIDTH: wib = (v > 16'hFFFF) ? 16'hFFFF : v[15:0];
            S_HEIGHT: hiu = (v > 16'hFFFF) ? 16'hFFFF : v[15:0];
            S_FMO: begin fld.fmo = v[0]; nxt = v[0] ? S_D8 : S_MBAFF; end
            S_CROPF: begin loops = 0; nxt = v[0] ? S_CROP : S_VUI; end
            S_CROP: begin
                crop[loops & 3] = (v > 16'hFFFF) ? 16'hFFFF : v[15:0];
                loops++;
                nxt = (loops >= 4) ? S_VUI : S_CROP;
            end
            S_VUI: begin fld.vui = v[0]; nxt = S_DONE; end
            default: ;
        endcase
        step = nxt;
    endtask

    // Feeds one bit to the shared fixed-width and Exp-Golomb reader.
    task automatic take_bit(logic b);
        int n;
        if (step == S_DONE) return;
        n = fixed_width(step);
        if (n != 0) begin
            acc = {acc[30:0], b};
            bits_in++;
            if (bits_in >= n) element_done(acc);
        end else if (bits_in == 0) begin
            if (!b) begin
                zeros++;
                if (zeros >= CODE_LIMIT) abort_parse(STS_OVF);
            end else if (zeros == 0) begin
                element_done(0);
            end else begin
                bits_in = 1;
                acc = '0;
            end
        end else begin
            acc = {acc[30:0], b};
            bits_in++;
            if (bits_in - 1 >= zeros)
                element_done(((64'd1 << zeros) - 1) + longint'(acc));
        end
    endtask

    // Forms the summary word at the end of a NAL unit; the caller then clears.
    function automatic sps_out_t summarise();
        sps_out_t s;
        longint unsigned w, h, ux, uy, fm, lim;
        s = '0;
        w = 0;
        h = 0;
        s.status = (err != STS_OK) ? err : ((step != S_DONE) ? STS_TRUNC : STS_OK);
        if (s.status == STS_OK) begin
            lim = (64'd1 << DIM_LIMIT) - 1;
            fm = 2 - fld.fmo;
            case (fld.chroma)
                8'd0, 8'd3: begin ux = 1; uy = fm; end
                8'd2:       begin ux = 2; uy = fm; end
                default:    begin ux = 2; uy = 2 * fm; end
            endcase
            w = (longint'(wib) + 1) * 16;
            h = fm * (longint'(hiu) + 1) * 16;
            ux = ux * (longint'(crop[0]) + crop[1]);
            uy = uy * (longint'(crop[2]) + crop[3]);
            if (w > lim || h > lim || ux >= w || uy >= h) begin
                s.status = STS_CROP;
                w = 0;
                h = 0;
            end else begin
                w = w - ux;
                h = h - uy;
            end
        end
        s.frame_width = w[15:0];
        s.frame_height = h[15:0];
        s.profile_code = fld.profile;
        s.level_code = fld.level;
        s.param_set_id = fld.sps_id;
        s.chroma_format = (fld.chroma > 3) ? 2'd3 : fld.chroma[1:0];
        s.frame_num_bits_minus4 = fld.fnum;
        s.order_count_type = fld.poc;
        s.ref_frame_count = fld.nref;
        s.frames_only = fld.fmo;
        s.vui_present = fld.vui;
        return s;
    endfunction

    task automatic check_field(string name, longint unsigned e, longint unsigned a);
        if (e != a) begin
            $display("%0t: mismatch in %s: expected %0d, actual %0d", $time, name, e, a);
            fail_count++;
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        sps_out_t e;
        sps_out_t a;
        if (!rst_n)
        begin
            clear_parser();
            summary_q.delete();
            fail_count = 0;
            outstanding = 0;
        end
        else
        begin
            if (nal_valid && !nal_stall)
            begin
                for (int i = 7; i >= 0; i--) take_bit(nal_word.data_byte[i]);
                if (nal_word.last_byte)
                begin
                    summary_q.push_back(summarise());
                    clear_parser();
                end
            end
            if (sps_valid && !sps_stall)
            begin
                a = sps_word;
                if (summary_q.size() == 0)
                begin
                    $display("%0t: unexpected summary word, expected none, actual %h",
                             $time, a);
                    fail_count++;
                end
                else
                begin
                    e = summary_q.pop_front();
                    check_field("status", e.status, a.status);
                    check_field("frame_width", e.frame_width, a.frame_width);
                    check_field("frame_height", e.frame_height, a.frame_height);
                    check_field("profile_code", e.profile_code, a.profile_code);
                    check_field("level_code", e.level_code, a.level_code);
                    check_field("param_set_id", e.param_set_id, a.param_set_id);
                    check_field("chroma_format", e.chroma_format, a.chroma_format);
                    check_field("frame_num_bits_minus4", e.frame_num_bits_minus4,
                                a.frame_num_bits_minus4);
                    check_field("order_count_type", e.order_count_type,
                                a.order_count_type);
                    check_field("ref_frame_count", e.ref_frame_count, a.ref_frame_count);
                    check_field("frames_only", e.frames_only, a.frames_only);
                    check_field("vui_present", e.vui_present, a.vui_present);
                end
            end
            outstanding = summary_q.size();
        end
    end

endmodule

### tb/sv/tb_top.sv
// ---------------------------------------------------------------------------
// SPS parser testbench
// Builds NAL units bit by bit (well-formed SPS units with random content,
// broken and foreign units, and raw noise), sends them with random idle
// bursts against a randomly stalling receiver, and reports the verdict of
// the checker.
// ---------------------------------------------------------------------------
module tb_top;
    import sps_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int WORD_TARGET = 1400;
    localparam int QUIET_AFTER = 1200;
    localparam int CYCLE_LIMIT = 400000;

    logic     clk = 1'b0;
    logic     rst_n = 1'b0;
    logic     nal_valid = 1'b0;
    logic     nal_stall;
    sps_in_t  nal_word = '0;
    logic     sps_valid;
    logic     sps_stall = 1'b0;
    sps_out_t sps_word;
    int       fail_count;
    int       outstanding;
    int       cycles = 0;
    int       words_sent = 0;
    bit       quiet = 1'b0;

    // Bits of the NAL unit under construction, first bit first.
    bit       unit_bits [$];

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    sps_header_parser DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .nal_valid (nal_valid),
        .nal_stall (nal_stall),
        .nal_word  (nal_word),
        .sps_valid (sps_valid),
        .sps_stall (sps_stall),
        .sps_word  (sps_word)
    );

    sps_checker u_checker (
        .clk         (clk),
        .rst_n       (rst_n),
        .nal_valid   (nal_valid),
        .nal_stall   (nal_stall),
        .nal_word    (nal_word),
        .sps_valid   (sps_valid),
        .sps_stall   (sps_stall),
        .sps_word    (sps_word),
        .fail_count  (fail_count),
        .outstanding (outstanding)
    );

    // A run that has not finished by now has hung.
    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("*** FAILED ***");
            $finish;
        end
    end

    // The receiver stalls in random bursts until the final quiet stretch.
    always
    begin
        @(posedge clk);
        if (!quiet && rst_n && $urandom_range(0, 3) == 0)
        begin
            sps_stall <= 1'b1;
            repeat ($urandom_range(1, 10)) @(posedge clk);
            sps_stall <= 1'b0;
        end
    end

    task automatic put_bits(longint unsigned v, int n);
        for (int i = n - 1; i >= 0; i--) unit_bits.push_back(v[i]);
    endtask

    // Unsigned Exp-Golomb code: the signed form shares the same bit layout.
    task automatic put_ue(longint unsigned v);
        longint unsigned x;
        int lz;
        x = v + 1;
        lz = 0;
        while ((x >> (lz + 1)) != 0) lz++;
        put_bits(0, lz);
        put_bits(x, lz + 1);
    endtask

    // Sends one word, sometimes with a random idle burst in front of it.
    task automatic send_word(logic [7:0] b, logic last);
        if (!quiet && $urandom_range(0, 4) == 0)
        begin
            nal_valid <= 1'b0;
            repeat ($urandom_range(1, 10)) @(posedge clk);
        end
        nal_valid <= 1'b1;
        nal_word <= '{data_byte: b, last_byte: last};
        @(negedge clk);
        while (nal_stall) @(negedge clk);
        @(posedge clk);
        words_sent++;
        if (words_sent >= QUIET_AFTER) quiet = 1'b1;
    endtask

    // Packs the built bits into bytes, zero padded, and sends them. A
    // non-zero keep count cuts the unit short to that many bytes.
    task automatic send_unit(int keep);
        logic [7:0] bytes [$];
        logic [7:0] b;
        while (unit_bits.size() % 8 != 0) unit_bits.push_back(1'b0);
        while (unit_bits.size() != 0)
        begin
            for (int i = 0; i < 8; i++) b = {b[6:0], logic'(unit_bits.pop_front())};
            bytes.push_back(b);
        end
        if (bytes.size() == 0) bytes.push_back(8'h00);
        if (keep > 0 && keep < bytes.size())
            while (bytes.size() > keep) void'(bytes.pop_back());
        foreach (bytes[i]) send_word(bytes[i], i == bytes.size() - 1);
    endtask

    function automatic longint unsigned pick(int lo, int hi, int wide_lo, int wide_hi);
        if ($urandom_range(0, 19) == 0) return $urandom_range(wide_lo, wide_hi);
        return $urandom_range(lo, hi);
    endfunction

    // Builds an SPS unit. Flavours: plain, long Exp-Golomb prefix, scaling
    // lists present, oversized crop or frame, cut short.
    typedef enum int { U_PLAIN, U_OVERFLOW, U_SCALING, U_BADCROP, U_TRUNC } unit_e;

    task automatic build_sps(bit fragmented, unit_e kind);
        logic [7:0] high_list [12] = '{100, 110, 122, 244, 44, 83, 86, 118,
                                        128, 138, 139, 134};
        logic [7:0] prof;
        longint unsigned chroma, poc, cyc;
        bit high, fmo;
        if (fragmented)
        begin
            put_bits({1'b0, 2'($urandom), 5'd28}, 8);
            put_bits({2'b10, 1'($urandom), 5'd7}, 8);
        end
        else
            put_bits({1'($urandom), 2'($urandom), 5'd7}, 8);
        prof = ($urandom_range(0, 1) != 0) ? high_list[$urandom_range(0, 11)]
                                           : 8'($urandom);
        high = prof inside {100, 110, 122, 244, 44, 83, 86, 118, 128, 138, 139, 134};
        put_bits(prof, 8);
        put_bits($urandom, 8);
        put_bits($urandom, 8);
        if (kind == U_OVERFLOW)
        begin
            put_bits(0, 32 + $urandom_range(0, 8));
            put_bits($urandom, 8);
            return;
        end
        put_ue(pick(0, 31, 32, 40));
        if (high)
        begin
            chroma = pick(0, 3, 4, 300);
            put_ue(chroma);
            if (chroma == 3) put_bits($urandom, 1);
            put_ue(pick(0, 8, 9, 20));
            put_ue(pick(0, 8, 9, 20));
            put_bits($urandom, 1);
            put_bits(kind == U_SCALING, 1);
            if (kind == U_SCALING)
            begin
                put_bits($urandom, 16);
                return;
            end
        end
        put_ue(pick(0, 12, 13, 30));
        poc = pick(0, 2, 3, 10);
        put_ue(poc);
        if (poc == 0)
            put_ue(pick(0, 12, 13, 40));
        else if (poc == 1)
        begin
            put_bits($urandom, 1);
            put_ue(pick(0, 100, 1000, 70000));
            put_ue(pick(0, 100, 1000, 70000));
            cyc = ($urandom_range(0, 29) == 0) ? $urandom_range(256, 300)
                                               : $urandom_range(0, 5);
            put_ue(cyc);
            for (int i = 0; i < cyc; i++) put_ue((cyc > 255) ? 0 : $urandom_range(0, 60));
        end
        put_ue(pick(0, 16, 17, 400));
        put_bits($urandom, 1);
        put_ue(pick(0, 120, 4000, 70000));
        put_ue(pick(0, 70, 2000, 70000));
        fmo = 1'($urandom);
        put_bits(fmo, 1);
        if (!fmo) put_bits($urandom, 1);
        put_bits($urandom, 1);
        if (kind == U_BADCROP || $urandom_range(0, 1) != 0)
        begin
            put_bits(1, 1);
            for (int i = 0; i < 4; i++)
                put_ue((kind == U_BADCROP) ? $urandom_range(0, 2000) : pick(0, 8, 9, 70000));
        end
        else
            put_bits(0, 1);
        put_bits($urandom, 1);
        put_bits($urandom, $urandom_range(0, 20));
    endtask

    initial
    begin
        int r;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: foreign unit, all-ones unit, truncated baseline SPS, an
        // FU-A with start and end bits set, truncated FU-A SPS, long prefix.
        put_bits(8'h00, 8);
        send_unit(0);
        put_bits(8'hFF, 8);
        send_unit(0);
        put_bits(8'h67, 8);
        put_bits(8'd66, 8);
        put_bits(0, 16);
        put_bits(8'b1111_1111, 8);
        put_bits(8'b1110_0000, 8);
        send_unit(0);
        put_bits(8'h7C, 8);
        put_bits(8'hC7, 8);
        send_unit(0);
        put_bits(8'h7C, 8);
        put_bits(8'h87, 8);
        put_bits(8'd100, 8);
        put_bits(0, 16);
        put_bits(8'b1101_1110, 8);
        send_unit(0);
        put_bits(8'h67, 8);
        put_bits(8'd244, 8);
        put_bits(8'hFF, 8);
        put_bits(8'hFF, 8);
        put_bits(0, 32);
        send_unit(0);

        // Random part: mostly well-formed SPS units, some broken, some noise.
        while (words_sent < WORD_TARGET)
        begin
            r = $urandom_range(0, 99);
            if (r < 10)
            begin
                repeat ($urandom_range(1, 6)) put_bits($urandom, 8);
                send_unit(0);
            end
            else if (r < 60)
            begin
                build_sps($urandom_range(0, 3) == 0, U_PLAIN);
                send_unit(0);
            end
            else if (r < 68)
            begin
                build_sps($urandom_range(0, 3) == 0, U_OVERFLOW);
                send_unit(0);
            end
            else if (r < 76)
            begin
                build_sps($urandom_range(0, 3) == 0, U_SCALING);
                send_unit(0);
            end
            else if (r < 86)
            begin
                build_sps($urandom_range(0, 3) == 0, U_BADCROP);
                send_unit(0);
            end
            else
            begin
                build_sps($urandom_range(0, 3) == 0, U_TRUNC);
                send_unit($urandom_range(1, 8));
            end
        end
        nal_valid <= 1'b0;

        @(posedge clk);
        while (outstanding != 0) @(posedge clk);
        repeat (30) @(posedge clk);
        if (fail_count == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule
